[rtl/core/uer_pkg.sv]
package uer_pkg;

    localparam int TIME_BITS = 16;
    localparam int COUNT_BITS = 10;
    localparam int DIST_BITS = 11;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};

    // len / 58 == (len >> 1) / 29, done as a multiply by a rounded-up reciprocal
    localparam longint unsigned HALF_DIVISOR = 29;
    localparam int RECIP_SHIFT = TIME_BITS + 5;
    localparam longint unsigned RECIP_MULT =
        ((64'd1 << RECIP_SHIFT) + HALF_DIVISOR - 1) / HALF_DIVISOR;
    localparam int RECIP_BITS = $clog2(RECIP_MULT + 1);
    localparam int PROD_BITS = TIME_BITS - 1 + RECIP_BITS;

    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIG_LOW      = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TRIG_HIGH     = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLE        = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RISE_TIMEOUT  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_TOTAL_TIMEOUT = 3'd4;

    localparam logic [7:0]  TRIG_LOW_RESET      = 8'd5;
    localparam logic [7:0]  TRIG_HIGH_RESET     = 8'd10;
    localparam logic [9:0]  SETTLE_RESET        = 10'd200;
    localparam logic [15:0] RISE_TIMEOUT_RESET  = 16'd1000;
    localparam logic [15:0] TOTAL_TIMEOUT_RESET = 16'd2000;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_TLOW   = 3'd1,
        PH_THIGH  = 3'd2,
        PH_SETTLE = 3'd3,
        PH_RISE   = 3'd4,
        PH_FALL   = 3'd5
    } phase_t;

    typedef struct packed {
        logic start_req;
        logic echo;
    } uer_in_beat_t;

    typedef struct packed {
        logic                 trig;
        logic                 busy_res;
        logic                 done_res;
        logic                 timed_out;
        logic [DIST_BITS-1:0] distance_cm;
    } uer_out_beat_t;

endpackage

[rtl/core/uer_in_if.sv]
interface uer_in_if import uer_pkg::*; ();

    logic         valid;
    logic         ready;
    uer_in_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

[rtl/core/uer_out_if.sv]
interface uer_out_if import uer_pkg::*; ();

    logic          valid;
    logic          ready;
    uer_out_beat_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);

endinterface

[rtl/core/ultrasonic_echo_ranger.sv]
// channel   dir  beat                                             accepted when
// tick      in   start_req, echo (one beat per microsecond)       tick.valid & tick.ready
// result    out  trig, busy_res, done_res, timed_out, distance_cm result.valid & result.ready
// cfg       in   cfg_index 3b, cfg_data 16b                       cfg_we
//
// One tick beat per clock while tick.ready is high; its result beat is out the next cycle.
// Throughput is set by the single result register: tick.ready drops only while
// that register is full and result.ready is low.
// Distance is one 15x17 reciprocal multiply in the same cycle as the state update.
// rst_n clears phase, counters, held result and restores register defaults.
module ultrasonic_echo_ranger import uer_pkg::*; (
    input  logic                     clk,
    input  logic                     rst_n,
    uer_in_if.sink                   tick,
    uer_out_if.source                result,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    logic [7:0]           trig_low_reg;
    logic [7:0]           trig_high_reg;
    logic [9:0]           settle_reg;
    logic [15:0]          rise_timeout_reg;
    logic [15:0]          total_timeout_reg;

    phase_t               phase_reg, phase_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [TIME_BITS-1:0] elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0] rise_time_reg, rise_time_next;
    logic [DIST_BITS-1:0] held_dist_reg, held_dist_next;
    logic                 held_to_reg, held_to_next;

    logic                 out_valid_reg;
    uer_out_beat_t        out_reg;
    uer_out_beat_t        beat_next;

    logic                 accept;
    phase_t               eff_phase;
    phase_t               after_phase;
    logic [COUNT_BITS-1:0] eff_count;
    logic [COUNT_BITS:0]  count_inc;
    logic [COUNT_BITS:0]  phase_len;
    logic [TIME_BITS-1:0] eff_elapsed;
    logic [TIME_BITS-1:0] elapsed_inc;
    logic [TIME_BITS-1:0] pulse_len;
    logic [PROD_BITS-1:0] product;
    logic [PROD_BITS-1:0] quotient;
    logic [DIST_BITS-1:0] distance;
    logic                 trig;
    logic                 done;

    function automatic phase_t skip_empty(phase_t p, logic low_z, logic high_z,
                                          logic settle_z);
        phase_t r;
        r = PH_RISE;
        unique case (p)
            PH_TLOW:
            begin
                if (!low_z)
                    r = PH_TLOW;
                else if (!high_z)
                    r = PH_THIGH;
                else if (!settle_z)
                    r = PH_SETTLE;
            end
            PH_THIGH:
            begin
                if (!high_z)
                    r = PH_THIGH;
                else if (!settle_z)
                    r = PH_SETTLE;
            end
            PH_SETTLE:
            begin
                if (!settle_z)
                    r = PH_SETTLE;
            end
            default:
            begin
                r = PH_RISE;
            end
        endcase
        return r;
    endfunction

    assign accept      = tick.valid && tick.ready;
    assign tick.ready  = !out_valid_reg || result.ready;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_reg;

    always_comb
    begin
        if (phase_reg == PH_IDLE && tick.payload.start_req)
        begin
            eff_phase = skip_empty(PH_TLOW, trig_low_reg == '0, trig_high_reg == '0,
                                   settle_reg == '0);
            eff_count = '0;
            eff_elapsed = (eff_phase == PH_RISE) ? '0 : elapsed_reg;
        end
        else
        begin
            eff_phase = phase_reg;
            eff_count = count_reg;
            eff_elapsed = elapsed_reg;
        end
    end

    always_comb
    begin
        unique case (eff_phase)
            PH_TLOW:
            begin
                phase_len = {3'b000, trig_low_reg};
                after_phase = skip_empty(PH_THIGH, 1'b0, trig_high_reg == '0,
                                         settle_reg == '0);
            end
            PH_THIGH:
            begin
                phase_len = {3'b000, trig_high_reg};
                after_phase = skip_empty(PH_SETTLE, 1'b0, 1'b0, settle_reg == '0);
            end
            PH_SETTLE:
            begin
                phase_len = {1'b0, settle_reg};
                after_phase = PH_RISE;
            end
            default:
            begin
                phase_len = '0;
                after_phase = PH_RISE;
            end
        endcase
    end

    assign count_inc   = {1'b0, eff_count} + 1'b1;
    assign elapsed_inc = (eff_elapsed == TIME_MAX) ? eff_elapsed : eff_elapsed + 1'b1;
    assign pulse_len   = eff_elapsed - rise_time_reg;
    assign product     = PROD_BITS'(pulse_len[TIME_BITS-1:1])
                         * PROD_BITS'(RECIP_MULT);
    assign quotient    = product >> RECIP_SHIFT;
    assign distance    = (quotient > PROD_BITS'(DIST_MAX)) ? DIST_MAX
                                                           : quotient[DIST_BITS-1:0];

    always_comb
    begin
        phase_next     = eff_phase;
        count_next     = eff_count;
        elapsed_next   = eff_elapsed;
        rise_time_next = rise_time_reg;
        held_dist_next = held_dist_reg;
        held_to_next   = held_to_reg;
        trig           = 1'b0;
        done           = 1'b0;
        unique case (eff_phase)
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            PH_TLOW, PH_THIGH, PH_SETTLE:
            begin
                trig = (eff_phase == PH_THIGH);
                if (count_inc >= phase_len)
                begin
                    phase_next = after_phase;
                    count_next = '0;
                    if (after_phase == PH_RISE)
                        elapsed_next = '0;
                end
                else
                begin
                    count_next = count_inc[COUNT_BITS-1:0];
                end
            end
            PH_RISE:
            begin
                if (tick.payload.echo)
                begin
                    rise_time_next = eff_elapsed;
                    phase_next = PH_FALL;
                    elapsed_next = elapsed_inc;
                end
                else if (eff_elapsed > TIME_BITS'(rise_timeout_reg)
                         || eff_elapsed == TIME_MAX)
                begin
                    held_to_next = 1'b1;
                    held_dist_next = '0;
                    phase_next = PH_IDLE;
                    count_next = '0;
                    done = 1'b1;
                end
                else
                begin
                    elapsed_next = elapsed_inc;
                end
            end
            PH_FALL:
            begin
                if (!tick.payload.echo)
                begin
                    held_to_next = 1'b0;
                    held_dist_next = distance;
                    phase_next = PH_IDLE;
                    count_next = '0;
                    done = 1'b1;
                end
                else if (eff_elapsed > TIME_BITS'(total_timeout_reg)
                         || eff_elapsed == TIME_MAX)
                begin
                    held_to_next = 1'b1;
                    held_dist_next = '0;
                    phase_next = PH_IDLE;
                    count_next = '0;
                    done = 1'b1;
                end
                else
                begin
                    elapsed_next = elapsed_inc;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        beat_next.trig        = trig;
        beat_next.busy_res    = (phase_next != PH_IDLE);
        beat_next.done_res    = done;
        beat_next.timed_out   = held_to_next;
        beat_next.distance_cm = held_dist_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trig_low_reg      <= TRIG_LOW_RESET;
            trig_high_reg     <= TRIG_HIGH_RESET;
            settle_reg        <= SETTLE_RESET;
            rise_timeout_reg  <= RISE_TIMEOUT_RESET;
            total_timeout_reg <= TOTAL_TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_TRIG_LOW:      trig_low_reg      <= cfg_data[7:0];
                CFG_TRIG_HIGH:     trig_high_reg     <= cfg_data[7:0];
                CFG_SETTLE:        settle_reg        <= cfg_data[9:0];
                CFG_RISE_TIMEOUT:  rise_timeout_reg  <= cfg_data[15:0];
                CFG_TOTAL_TIMEOUT: total_timeout_reg <= cfg_data[15:0];
                default:
                begin
                    trig_low_reg <= trig_low_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            elapsed_reg   <= '0;
            rise_time_reg <= '0;
            held_dist_reg <= '0;
            held_to_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            elapsed_reg   <= elapsed_next;
            rise_time_reg <= rise_time_next;
            held_dist_reg <= held_dist_next;
            held_to_reg   <= held_to_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // hold the beat until taken
    always_ff @(posedge clk)
    begin
        if (accept)
            out_reg <= beat_next;
    end

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.done_res |-> !out_reg.busy_res)
        else $error("done beat reports busy");

    a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.trig |-> out_reg.busy_res)
        else $error("trigger high outside a measurement");

    a_timeout_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.timed_out |-> out_reg.distance_cm == '0)
        else $error("timeout with nonzero distance");

    a_fall_elapsed: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_FALL |-> elapsed_reg != '0)
        else $error("pulse timing without elapsed advance");

endmodule

[dv/ultrasonic_echo_ranger_checker.sv]
`timescale 1ns / 100ps

module ultrasonic_echo_ranger_checker
    import uer_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     tick_valid,
    input  logic                     tick_ready,
    input  uer_in_beat_t             tick_beat,
    input  logic                     res_valid,
    input  logic                     res_ready,
    input  uer_out_beat_t            res_beat,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    output int                       fail_count,
    output int                       pending,
    output logic                     model_busy,
    output int                       n_results,
    output int                       n_done,
    output int                       n_timeout
);

    localparam int TICKS_PER_CM = 58;

    logic [7:0]           cfg_tlow;
    logic [7:0]           cfg_thigh;
    logic [9:0]           cfg_settle;
    logic [15:0]          cfg_rise_to;
    logic [15:0]          cfg_total_to;

    phase_t               ph;
    logic [COUNT_BITS-1:0] phase_cnt;
    logic [TIME_BITS-1:0] elapsed;
    logic [TIME_BITS-1:0] rise_at;
    logic [DIST_BITS-1:0] held_dist;
    logic                 held_to;

    uer_out_beat_t        ranger_results[$];

    assign model_busy = (ph != PH_IDLE);

    function automatic logic [COUNT_BITS-1:0] phase_len(phase_t p);
        case (p)
            PH_TLOW:   return COUNT_BITS'(cfg_tlow);
            PH_THIGH:  return COUNT_BITS'(cfg_thigh);
            PH_SETTLE: return cfg_settle;
            default:   return '0;
        endcase
    endfunction

    task automatic enter_phase(input phase_t p);
        phase_cnt = '0;
        while ((p == PH_TLOW || p == PH_THIGH || p == PH_SETTLE) && phase_len(p) == '0)
            p = phase_t'(p + 1);
        if (p == PH_RISE)
            elapsed = '0;
        ph = p;
    endtask

    task automatic bump_elapsed();
        if (elapsed != TIME_MAX)
            elapsed = elapsed + 1'b1;
    endtask

    task automatic conclude(input logic by_timeout, input logic [DIST_BITS-1:0] dist_cm);
        held_to   = by_timeout;
        held_dist = by_timeout ? '0 : dist_cm;
        ph        = PH_IDLE;
        phase_cnt = '0;
    endtask

    task automatic advance_ranger(input uer_in_beat_t b, output uer_out_beat_t r);
        logic                 trig_v;
        logic                 done_v;
        logic [TIME_BITS-1:0] span;
        logic [TIME_BITS-1:0] quot;
        trig_v = 1'b0;
        done_v = 1'b0;
        if (ph == PH_IDLE && b.start_req)
            enter_phase(PH_TLOW);
        case (ph)
            PH_TLOW, PH_THIGH, PH_SETTLE:
            begin
                trig_v = (ph == PH_THIGH);
                phase_cnt = phase_cnt + 1'b1;
                if (phase_cnt >= phase_len(ph))
                    enter_phase(phase_t'(ph + 1));
            end
            PH_RISE:
            begin
                if (b.echo)
                begin
                    rise_at = elapsed;
                    ph = PH_FALL;
                    bump_elapsed();
                end
                else if (elapsed > cfg_rise_to || elapsed == TIME_MAX)
                begin
                    conclude(1'b1, '0);
                    done_v = 1'b1;
                end
                else
                begin
                    bump_elapsed();
                end
            end
            PH_FALL:
            begin
                if (!b.echo)
                begin
                    span = (elapsed >= rise_at) ? elapsed - rise_at : '0;
                    quot = span / TIME_BITS'(TICKS_PER_CM);
                    conclude(1'b0, (quot > DIST_MAX) ? DIST_MAX : quot[DIST_BITS-1:0]);
                    done_v = 1'b1;
                end
                else if (elapsed > cfg_total_to || elapsed == TIME_MAX)
                begin
                    conclude(1'b1, '0);
                    done_v = 1'b1;
                end
                else
                begin
                    bump_elapsed();
                end
            end
            default:
            begin
                ph = PH_IDLE;
            end
        endcase
        r.trig        = trig_v;
        r.busy_res    = (ph != PH_IDLE);
        r.done_res    = done_v;
        r.timed_out   = held_to;
        r.distance_cm = held_dist;
    endtask

    function automatic int field_bad(string name, logic [15:0] exp_v, logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            $error("%s expected %0d actual %0d", name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        uer_out_beat_t want;
        uer_out_beat_t got;
        int            bad;
        if (!rst_n)
        begin
            cfg_tlow     = TRIG_LOW_RESET;
            cfg_thigh    = TRIG_HIGH_RESET;
            cfg_settle   = SETTLE_RESET;
            cfg_rise_to  = RISE_TIMEOUT_RESET;
            cfg_total_to = TOTAL_TIMEOUT_RESET;
            ph           = PH_IDLE;
            phase_cnt    = '0;
            elapsed      = '0;
            rise_at      = '0;
            held_dist    = '0;
            held_to      = 1'b0;
            ranger_results.delete();
            fail_count   = 0;
            pending      = 0;
            n_results    = 0;
            n_done       = 0;
            n_timeout    = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_TRIG_LOW:      cfg_tlow     = cfg_data[7:0];
                    CFG_TRIG_HIGH:     cfg_thigh    = cfg_data[7:0];
                    CFG_SETTLE:        cfg_settle   = cfg_data[9:0];
                    CFG_RISE_TIMEOUT:  cfg_rise_to  = cfg_data;
                    CFG_TOTAL_TIMEOUT: cfg_total_to = cfg_data;
                    default: ;
                endcase
            end
            if (res_valid && res_ready)
            begin
                got = res_beat;
                n_results++;
                if (got.done_res === 1'b1)
                begin
                    n_done++;
                    if (got.timed_out === 1'b1)
                        n_timeout++;
                end
                if (ranger_results.size() == 0)
                begin
                    $error("result beat with no expected result waiting");
                    fail_count++;
                end
                else
                begin
                    want = ranger_results.pop_front();
                    bad = field_bad("trig", 16'(want.trig), 16'(got.trig))
                        + field_bad("busy_res", 16'(want.busy_res), 16'(got.busy_res))
                        + field_bad("done_res", 16'(want.done_res), 16'(got.done_res))
                        + field_bad("timed_out", 16'(want.timed_out), 16'(got.timed_out))
                        + field_bad("distance_cm", 16'(want.distance_cm),
                                    16'(got.distance_cm));
                    if (bad != 0)
                        fail_count++;
                end
            end
            if (tick_valid && tick_ready)
            begin
                advance_ranger(tick_beat, want);
                ranger_results.push_back(want);
            end
            pending = ranger_results.size();
        end
    end

endmodule

[dv/ultrasonic_echo_ranger_tb.sv]
`timescale 1ns / 100ps

module ultrasonic_echo_ranger_tb;
    import uer_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_PHASES = 4;
    localparam int ITEMS_PER_PHASE = 150;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    uer_in_if  tick_if ();
    uer_out_if res_if ();

    int   fail_count;
    int   pending;
    logic model_busy;
    int   n_results;
    int   n_done;
    int   n_timeout;

    int   cycles;
    bit   idle_en;
    bit   long_hold;
    bit   counting;
    int   rand_items;
    int   n_settings;
    int   cur_tl;
    int   cur_th;
    int   cur_st;
    int   cur_rt;
    int   cur_tt;

    ultrasonic_echo_ranger u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick_if),
        .result    (res_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    ultrasonic_echo_ranger_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_if.valid),
        .tick_ready (tick_if.ready),
        .tick_beat  (tick_if.payload),
        .res_valid  (res_if.valid),
        .res_ready  (res_if.ready),
        .res_beat   (res_if.payload),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending),
        .model_busy (model_busy),
        .n_results  (n_results),
        .n_done     (n_done),
        .n_timeout  (n_timeout)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("ultrasonic_echo_ranger_tb failed");
            $finish;
        end
    end

    // result side: short random stalls, one long hold-off on request
    initial
    begin
        res_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                long_hold = 1'b0;
                res_if.ready <= 1'b1;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge clk);
                res_if.ready <= 1'b1;
            end
            else
            begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // entered and left at a falling edge; valid stays high for the next beat
    task automatic send_tick(input logic s, input logic e);
        uer_in_beat_t b;
        if (idle_en && $urandom_range(0, 7) == 0)
        begin
            tick_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        b.start_req = s;
        b.echo      = e;
        tick_if.valid   <= 1'b1;
        tick_if.payload <= b;
        @(posedge clk);
        while (!tick_if.ready) @(posedge clk);
        if (counting)
            rand_items++;
        @(negedge clk);
    endtask

    // drain the measurement in flight, then wait for every result beat
    task automatic quiesce();
        logic e;
        e = 1'b0;
        while (model_busy)
        begin
            send_tick(1'b0, e);
            e = ~e;
        end
        tick_if.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
    endtask

    task automatic set_config(input int tl, th, st, rt, tt);
        logic [CFG_IDX_BITS-1:0]  idx[5];
        logic [CFG_DATA_BITS-1:0] vals[5];
        logic [CFG_DATA_BITS-1:0] junk;
        junk    = 16'($urandom);
        idx     = '{CFG_TRIG_LOW, CFG_TRIG_HIGH, CFG_SETTLE, CFG_RISE_TIMEOUT,
                    CFG_TOTAL_TIMEOUT};
        vals[0] = {junk[15:8], 8'(tl)};
        vals[1] = {junk[7:0], 8'(th)};
        vals[2] = {junk[15:10], 10'(st)};
        vals[3] = 16'(rt);
        vals[4] = 16'(tt);
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(negedge clk);
        end
        cfg_index <= CFG_TOTAL_TIMEOUT + CFG_IDX_BITS'($urandom_range(1, 3));
        cfg_data  <= 16'($urandom);
        @(negedge clk);
        cfg_we <= 1'b0;
        cur_tl = tl;
        cur_th = th;
        cur_st = st;
        cur_rt = rt;
        cur_tt = tt;
        n_settings++;
    endtask

    // start, trigger and settle ticks, then d_low low echo, h_high high echo, tail low
    task automatic measure(input int d_low, input int h_high, input int tail);
        int   pre;
        int   n;
        logic s;
        logic e;
        pre = cur_tl + cur_th + cur_st;
        n   = pre + d_low + h_high + tail;
        for (int j = 0; j < n; j++)
        begin
            if (j < pre)
            begin
                s = (j == 0) || ($urandom_range(0, 3) == 0);
                e = 1'($urandom_range(0, 1));
            end
            else
            begin
                s = (j == 0);
                e = (j >= pre + d_low) && (j < pre + d_low + h_high);
            end
            send_tick(s, e);
        end
    endtask

    initial
    begin
        int tl;
        int th;
        int st;
        int rt;
        int tt;
        int h;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        tick_if.valid   = 1'b0;
        tick_if.payload = '0;
        cycles          = 0;
        idle_en         = 1'b1;
        long_hold       = 1'b0;
        counting        = 1'b0;
        rand_items      = 0;
        n_settings      = 0;
        cur_tl          = TRIG_LOW_RESET;
        cur_th          = TRIG_HIGH_RESET;
        cur_st          = SETTLE_RESET;
        cur_rt          = RISE_TIMEOUT_RESET;
        cur_tt          = TOTAL_TIMEOUT_RESET;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // register defaults, idle ticks ignored
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        measure(4, 120, 2);
        quiesce();

        // rise timeout, pulse timeout, short success
        set_config(0, 1, 0, 3, 5);
        measure(10, 0, 1);
        measure(0, 10, 1);
        measure(1, 3, 1);
        quiesce();

        // every trigger phase skipped, zero timeouts
        set_config(0, 0, 0, 0, 0);
        measure(0, 1, 1);
        measure(2, 0, 1);
        measure(0, 3, 1);
        quiesce();

        counting = 1'b1;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            tl = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
            th = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6);
            st = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
            rt = $urandom_range(0, 30);
            tt = $urandom_range(0, 300);
            set_config(tl, th, st, rt, tt);
            if (p == 1)
                long_hold = 1'b1;
            if (p == RAND_PHASES - 1)
                idle_en = 1'b0;
            while (rand_items < (p + 1) * ITEMS_PER_PHASE)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    repeat ($urandom_range(3, 10))
                        send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                end
                else
                begin
                    h = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 10)
                                                    : $urandom_range(0, tt + 20);
                    measure($urandom_range(0, rt + 3), h, $urandom_range(1, 4));
                end
            end
            quiesce();
        end
        counting = 1'b0;

        repeat (10) @(negedge clk);
        $display("covered %0d result beats over %0d register settings", n_results, n_settings);
        $display("%0d measurements ended, %0d of them by timeout", n_done, n_timeout);
        if (fail_count == 0 && pending == 0)
        begin
            $display("ultrasonic_echo_ranger_tb passed");
        end
        else
        begin
            $display("ultrasonic_echo_ranger_tb failed");
        end
        $finish;
    end

endmodule
